// ===== rtl/ilc_pkg.sv =====
// shared types, field widths and codes for the indexed list block
// no dependencies
package ilc_pkg;

    // default sizing of the list
    localparam int ILC_DEPTH  = 1024;
    localparam int ILC_DATA_W = 32;

    // fixed request and response field widths
    localparam int ILC_FUNC_W   = 2;
    localparam int ILC_INDEX_W  = 10;
    localparam int ILC_VALUE_W  = 32;
    localparam int ILC_RDATA_W  = 32;
    localparam int ILC_COUNT_W  = 11;
    localparam int ILC_MOD_W    = 16;
    localparam int ILC_STATUS_W = 2;

    // operation codes
    localparam logic [ILC_FUNC_W-1:0] OP_APPEND = 2'd0;
    localparam logic [ILC_FUNC_W-1:0] OP_READ   = 2'd1;
    localparam logic [ILC_FUNC_W-1:0] OP_REMOVE = 2'd2;

    // status codes
    localparam logic [ILC_STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [ILC_STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ILC_STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [ILC_FUNC_W-1:0]  func;
        logic [ILC_INDEX_W-1:0] index;
        logic [ILC_VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [ILC_RDATA_W-1:0]  data;
        logic [ILC_COUNT_W-1:0]  count;
        logic [ILC_MOD_W-1:0]    mod_count;
        logic [ILC_STATUS_W-1:0] status;
    } t_rsp;

    // commands broadcast from the controller to every cell
    typedef struct packed {
        logic append;   // cell at the given position takes the new value
        logic load;     // every tap takes its cell's element
        logic compact;  // cells at or above the given position take their neighbor's element
        logic shift;    // tap chain moves one place toward cell zero
    } t_cell_cmd;

endpackage

// ===== rtl/ilc_if.sv =====
// valid/ready channel interfaces for requests and responses
// depends on ilc_pkg
interface ilc_req_if;
    import ilc_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ilc_rsp_if;
    import ilc_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/ilc_cell.sv =====
// one storage cell of the list: an element register and a read tap
// depends on ilc_pkg
module ilc_cell #(
    parameter int DATA_WIDTH = ilc_pkg::ILC_DATA_W,
    parameter int IDX_W      = 10,
    parameter int POS        = 0
) (
    input  logic                  i_clk,
    input  ilc_pkg::t_cell_cmd    i_cmd,
    input  logic [IDX_W-1:0]      i_pos,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_next_elem,
    input  logic [DATA_WIDTH-1:0] i_next_tap,
    output logic [DATA_WIDTH-1:0] o_elem,
    output logic [DATA_WIDTH-1:0] o_tap
);
    import ilc_pkg::*;

    localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

    logic [DATA_WIDTH-1:0] r_elem;
    logic [DATA_WIDTH-1:0] r_tap;

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && (i_pos == MY_POS)) begin
            r_elem <= i_value;
        end else if (i_cmd.compact && (i_pos <= MY_POS)) begin
            r_elem <= i_next_elem;
        end

        if (i_cmd.load) begin
            r_tap <= r_elem;
        end else if (i_cmd.shift) begin
            r_tap <= i_next_tap;
        end
    end

    assign o_elem = r_elem;
    assign o_tap  = r_tap;
endmodule

// ===== rtl/ilc_ctrl.sv =====
// sequencer: decodes requests, keeps count and change counter, drives the cell row
// depends on ilc_pkg and ilc_if
module ilc_ctrl #(
    parameter int DEPTH      = ilc_pkg::ILC_DEPTH,
    parameter int DATA_WIDTH = ilc_pkg::ILC_DATA_W,
    parameter int IDX_W      = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ilc_req_if.sink               i_req,
    ilc_rsp_if.source             o_rsp,
    output ilc_pkg::t_cell_cmd    o_cmd,
    output logic [IDX_W-1:0]      o_pos,
    output logic [DATA_WIDTH-1:0] o_value,
    input  logic [DATA_WIDTH-1:0] i_tap0
);
    import ilc_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > ILC_INDEX_W) ? CNT_W : ILC_INDEX_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_HOLD} t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [ILC_MOD_W-1:0] r_mod, n_mod;
    logic [IDX_W-1:0] r_steps, n_steps;
    t_rsp             r_res, n_res;
    t_rsp             r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic      accept;
    logic      out_free;
    logic      idx_ok;
    logic      res_fire;
    t_rsp      res;
    t_cell_cmd cmd;
    logic [IDX_W-1:0] pos;

    assign accept   = i_req.valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || o_rsp.ready;
    assign idx_ok   = CMP_W'(i_req.payload.index) < CMP_W'(r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_mod       = r_mod;
        n_steps     = r_steps;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        cmd         = '0;
        pos         = IDX_W'(i_req.payload.index);
        res_fire    = 1'b0;
        res         = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    res_fire = 1'b1;
                    case (i_req.payload.func)
                        OP_APPEND: begin
                            if (r_count >= FULL_CNT) begin
                                res.status = ST_FULL;
                            end else begin
                                cmd.append = 1'b1;
                                pos        = IDX_W'(r_count);
                                n_count    = r_count + CNT_W'(1);
                                n_mod      = r_mod + ILC_MOD_W'(1);
                            end
                        end
                        OP_READ, OP_REMOVE: begin
                            if (!idx_ok) begin
                                res.status = ST_RANGE;
                            end else begin
                                res_fire = 1'b0;
                                cmd.load = 1'b1;
                                n_steps  = IDX_W'(i_req.payload.index);
                                n_state  = S_SHIFT;
                                if (i_req.payload.func == OP_REMOVE) begin
                                    cmd.compact = 1'b1;
                                    n_count     = r_count - CNT_W'(1);
                                    n_mod       = r_mod + ILC_MOD_W'(1);
                                end
                            end
                        end
                        default: begin
                            res.status = ST_OK;
                        end
                    endcase
                    res.count     = ILC_COUNT_W'(n_count);
                    res.mod_count = n_mod;
                end
            end
            S_SHIFT: begin
                if (r_steps == '0) begin
                    // requested element has reached the head of the tap chain
                    res_fire      = 1'b1;
                    res.data      = ILC_RDATA_W'(i_tap0);
                    res.count     = ILC_COUNT_W'(r_count);
                    res.mod_count = r_mod;
                    res.status    = ST_OK;
                end else begin
                    cmd.shift = 1'b1;
                    n_steps   = r_steps - IDX_W'(1);
                end
            end
            S_HOLD: begin
                res_fire = 1'b1;
                res      = r_res;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (res_fire) begin
            if (out_free) begin
                n_out       = res;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end else begin
                n_res   = res;
                n_state = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_mod       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_mod       <= n_mod;
            r_out_valid <= n_out_valid;
        end
        r_steps <= n_steps;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;
    assign o_cmd         = cmd;
    assign o_pos         = pos;
    assign o_value       = DATA_WIDTH'(i_req.payload.value);
endmodule

// ===== rtl/indexed_list_with_compaction_top.sv =====
// top level of the indexed list: controller plus a row of DEPTH storage cells
// depends on ilc_pkg, ilc_if, ilc_cell and ilc_ctrl

// An ordered list of up to DEPTH elements held in a row of identical cells,
// element k in cell k. Each request is an append, a read at an index or a
// remove at an index, and gets exactly one response with the data, the count
// after the operation, the 16-bit wrapping change counter and a status (ok,
// index out of range, list full). An append has the cell at the end position
// load the value in place; every rejected or unused request is answered from
// the idle state. Read and remove at index k start by loading: every cell
// copies its element into its own tap register (and, for remove, every cell
// at or above k takes its upper neighbor's element, so the list is compacted
// at once); then the tap chain moves one place toward cell zero per cycle
// until element k sits in cell zero's tap. The tap chain walk sets the
// latency of read and remove. One request is in flight at a time; the
// response sits in an output register, and a finished response that cannot
// leave yet is parked so the controller can return to idle once the output
// register drains. Entries above the count are never read.
module indexed_list_with_compaction_top #(
    parameter int DEPTH      = ilc_pkg::ILC_DEPTH,
    parameter int DATA_WIDTH = ilc_pkg::ILC_DATA_W
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ilc_req_if.sink   i_req,
    ilc_rsp_if.source o_rsp
);
    import ilc_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    // broadcast controls to the cell row
    t_cell_cmd             w_cmd;
    logic [IDX_W-1:0]      w_pos;
    logic [DATA_WIDTH-1:0] w_value;

    // neighbor links along the row
    logic [DATA_WIDTH-1:0] w_elem [DEPTH];
    logic [DATA_WIDTH-1:0] w_tap  [DEPTH];

    ilc_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_cmd   (w_cmd),
        .o_pos   (w_pos),
        .o_value (w_value),
        .i_tap0  (w_tap[0])
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_next_elem;
        logic [DATA_WIDTH-1:0] w_next_tap;

        if (g == DEPTH - 1) begin : g_last
            // last cell has no upper neighbor; it only matters past the count
            assign w_next_elem = w_elem[g];
            assign w_next_tap  = w_tap[g];
        end else begin : g_mid
            assign w_next_elem = w_elem[g+1];
            assign w_next_tap  = w_tap[g+1];
        end

        ilc_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .POS        (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_pos       (w_pos),
            .i_value     (w_value),
            .i_next_elem (w_next_elem),
            .i_next_tap  (w_next_tap),
            .o_elem      (w_elem[g]),
            .o_tap       (w_tap[g])
        );
    end
endmodule

// ===== sim/tb_top.sv =====
// testbench for indexed_list_with_compaction_top: directed, random and closing phases
// a small scoreboard mirrors the list and checks each response field by field
// depends on ilc_pkg, ilc_if and indexed_list_with_compaction_top
module tb_top;
    import ilc_pkg::*;

    // func 3 has no operation behind it
    localparam logic [ILC_FUNC_W-1:0] OP_UNUSED = 2'd3;

    localparam int     RAND_ITEMS   = 550;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     DRAIN_CYCLES = ILC_DEPTH + 16;
    localparam longint CYCLE_LIMIT  = 64'd4_000_000;

    // mirror of the list, and the responses it still owes
    class list_scoreboard;
        logic [ILC_DATA_W-1:0] elem_mirror [ILC_DEPTH];
        int                    elem_count = 0;
        logic [ILC_MOD_W-1:0]  change_cnt = '0;
        t_rsp                  list_rsp_q [$];
        int                    err_cnt = 0;

        // apply one accepted request to the mirror and queue its response
        function void note_request(t_req r);
            t_rsp e;
            int   pos;
            int   i;
            e = '0;
            e.status = ST_OK;
            pos = int'(r.index);
            case (r.func)
                OP_APPEND: begin
                    if (elem_count >= ILC_DEPTH) begin
                        e.status = ST_FULL;
                    end else begin
                        elem_mirror[elem_count] = r.value;
                        elem_count++;
                        change_cnt++;
                    end
                end
                OP_READ: begin
                    if (pos >= elem_count) begin
                        e.status = ST_RANGE;
                    end else begin
                        e.data = elem_mirror[pos];
                    end
                end
                OP_REMOVE: begin
                    if (pos >= elem_count) begin
                        e.status = ST_RANGE;
                    end else begin
                        e.data = elem_mirror[pos];
                        for (i = pos; i + 1 < elem_count; i++) begin
                            elem_mirror[i] = elem_mirror[i + 1];
                        end
                        elem_count--;
                        change_cnt++;
                    end
                end
                default: begin
                end
            endcase
            e.count     = ILC_COUNT_W'(elem_count);
            e.mod_count = change_cnt;
            list_rsp_q.push_back(e);
        endfunction

        // compare one accepted response with the oldest one owed
        function void check_response(t_rsp got);
            t_rsp e;
            if (list_rsp_q.size() == 0) begin
                $error("response with nothing outstanding: data %h count %0d status %0d",
                       got.data, got.count, got.status);
                err_cnt++;
                return;
            end
            e = list_rsp_q.pop_front();
            if (got.data !== e.data) begin
                $error("data mismatch: expected %h, actual %h", e.data, got.data);
                err_cnt++;
            end
            if (got.count !== e.count) begin
                $error("count mismatch: expected %0d, actual %0d", e.count, got.count);
                err_cnt++;
            end
            if (got.mod_count !== e.mod_count) begin
                $error("mod_count mismatch: expected %0d, actual %0d", e.mod_count,
                       got.mod_count);
                err_cnt++;
            end
            if (got.status !== e.status) begin
                $error("status mismatch: expected %0d, actual %0d", e.status, got.status);
                err_cnt++;
            end
        endfunction
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    longint cycle_cnt = 0;

    // no idling on either side while set
    bit fast_mode = 1'b0;
    // asks the response side for one long hold-off
    bit hold_req = 1'b0;

    list_scoreboard sb = new;

    ilc_req_if req_ch ();
    ilc_rsp_if rsp_ch ();

    indexed_list_with_compaction_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // offer one request after an optional gap and wait for it to be taken;
    // valid stays high afterward so back-to-back requests need no lowering
    task automatic send_req(input logic [ILC_FUNC_W-1:0] fn,
                            input logic [ILC_INDEX_W-1:0] idx,
                            input logic [ILC_VALUE_W-1:0] val);
        t_req r;
        int   gap;
        r.func  = fn;
        r.index = idx;
        r.value = val;
        gap = fast_mode ? 0 : pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(r);
    endtask

    // random element value with the extremes mixed in
    function automatic logic [ILC_VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return ILC_VALUE_W'($urandom);
    endfunction

    // response side: check what is taken, then choose ready for the next edge
    initial begin : rsp_side
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                sb.check_response(rsp_ch.payload);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                // long hold-off so the block backs up into the request side
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (fast_mode) begin
                rsp_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // runaway guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stim
        int                     n;
        int                     cnt;
        int                     sel;
        logic [ILC_INDEX_W-1:0] idx;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        i_rst_n        <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, extremes of value and index, every operation
        send_req(OP_READ,   10'd0,   32'h0);            // read from empty list
        send_req(OP_REMOVE, 10'd0,   32'h0);            // remove from empty list
        send_req(OP_READ,   10'h3ff, 32'h0);
        send_req(OP_REMOVE, 10'h3ff, 32'h0);
        send_req(OP_UNUSED, 10'h3ff, 32'hffff_ffff);    // unused func code
        send_req(OP_APPEND, 10'h3ff, 32'h0);            // index ignored on append
        send_req(OP_APPEND, 10'd0,   32'hffff_ffff);
        send_req(OP_APPEND, 10'd0,   32'ha5a5_a5a5);
        send_req(OP_APPEND, 10'd0,   32'h5a5a_5a5a);
        send_req(OP_READ,   10'd0,   32'h0);
        send_req(OP_READ,   10'd1,   32'h0);
        send_req(OP_READ,   10'd3,   32'h0);
        send_req(OP_READ,   10'd4,   32'h0);            // one past the end
        send_req(OP_REMOVE, 10'd4,   32'h0);
        send_req(OP_REMOVE, 10'd1,   32'h0);            // middle element
        send_req(OP_READ,   10'd1,   32'h0);
        send_req(OP_REMOVE, 10'd2,   32'h0);            // last element
        send_req(OP_UNUSED, 10'd0,   32'h1234_5678);
        send_req(OP_REMOVE, 10'd0,   32'h0);            // first element
        send_req(OP_READ,   10'd0,   32'h0);
        send_req(OP_REMOVE, 10'd0,   32'h0);            // list back to empty
        send_req(OP_READ,   10'd0,   32'h0);

        // random mix on a short list, opening with a long response hold-off
        hold_req = 1'b1;
        for (n = 0; n < RAND_ITEMS; n++) begin
            cnt = sb.elem_count;
            sel = $urandom_range(0, 99);
            if (cnt == 0 || $urandom_range(0, 9) == 0) begin
                idx = ILC_INDEX_W'($urandom_range(cnt, ILC_DEPTH - 1));
            end else begin
                idx = ILC_INDEX_W'($urandom_range(0, cnt - 1));
            end
            if (sel < 5) begin
                send_req(OP_UNUSED, ILC_INDEX_W'($urandom), pick_value());
            end else if (sel < ((cnt > 40) ? 25 : 45)) begin
                send_req(OP_APPEND, ILC_INDEX_W'($urandom), pick_value());
            end else if (sel < 72) begin
                send_req(OP_READ, idx, pick_value());
            end else begin
                send_req(OP_REMOVE, idx, pick_value());
            end
        end

        // deepest indices against the short list, then the head
        send_req(OP_READ,   10'h3ff, 32'h0);            // last slot of the store
        send_req(OP_REMOVE, 10'h3ff, 32'h0);
        send_req(OP_UNUSED, 10'h155, 32'h0);
        send_req(OP_APPEND, 10'h3ff, pick_value());
        send_req(OP_READ,   10'd0,   32'h0);
        send_req(OP_REMOVE, 10'd0,   32'h0);            // compacts the whole list
        send_req(OP_READ,   10'h200, 32'h0);

        // drain: everything owed must arrive, then nothing more
        req_ch.valid <= 1'b0;
        fast_mode = 1'b1;
        while (sb.list_rsp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.err_cnt == 0 && sb.list_rsp_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
